// ===== src/tln_pkg.sv =====
// Shared types, widths and codes of the triangular lattice neighbor index unit.
// Used by every module of the block but the queue; depends on nothing.
package tln_pkg;

	localparam int SITE_W  = 20;
	localparam int DIR_W   = 3;
	localparam int LEN_W   = 10;
	localparam int COORD_W = 10;
	localparam int EXT_W   = 11;
	localparam int VOL_W   = 21;
	localparam int BOND_W  = 22;

	localparam int NUM_DIRS = 6;

	// site mod volume takes one quotient bit per stage, then base / extent_x
	// takes one bit per stage for the y coordinate
	localparam int DIV1_STAGES  = SITE_W;
	localparam int DIV2_STAGES  = COORD_W;
	localparam int FRONT_STAGES = DIV1_STAGES + DIV2_STAGES;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 72;
	localparam int CFG_IDX_W = 1;

	localparam logic [EXT_W-1:0] MAX_EXTENT = 11'd1024;
	localparam logic [EXT_W-1:0] EXT_RESET  = 11'd16;
	localparam logic [VOL_W-1:0] VOL_RESET  = 21'd256;

	// lattice directions
	localparam logic [DIR_W-1:0] DIR_PY   = 3'd0;
	localparam logic [DIR_W-1:0] DIR_PX   = 3'd1;
	localparam logic [DIR_W-1:0] DIR_MYPX = 3'd2;
	localparam logic [DIR_W-1:0] DIR_PYMX = 3'd3;
	localparam logic [DIR_W-1:0] DIR_MX   = 3'd4;
	localparam logic [DIR_W-1:0] DIR_MY   = 3'd5;
	localparam logic [DIR_W-1:0] DIR_NONE = 3'd6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_Y = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_X = 1'b1;

	typedef struct packed {
		logic [EXT_W-1:0] ey;
		logic [EXT_W-1:0] ex;
		logic [VOL_W-1:0] vol;
	} lattice_cfg_t;

	// classified query handed from the front to the back
	typedef struct packed {
		logic [SITE_W-1:0]  base;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
		logic [LEN_W-1:0]   ly;
		logic [LEN_W-1:0]   lx;
		logic [DIR_W-1:0]   dir;
		logic [SITE_W-1:0]  other;
		logic               err;
	} q_item_t;

	function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] e);
		logic [EXT_W-1:0] r;
		r = e;
		if (e == '0) begin
			r = EXT_W'(1);
		end else if (e > MAX_EXTENT) begin
			r = MAX_EXTENT;
		end
		return r;
	endfunction

endpackage

// ===== src/tln_front.sv =====
// Front of the neighbor index unit: accepts queries and splits the site into
// coordinates through a pipelined restoring divider. Depends on tln_pkg.
module tln_front
	import tln_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  lattice_cfg_t        cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SITE_W-1:0]   site,
	input  logic [DIR_W-1:0]    dir,
	input  logic [LEN_W-1:0]    step_length,
	input  logic [SITE_W-1:0]   other_site,
	input  logic                q_full,
	output logic                q_push,
	output q_item_t             q_item
);

	typedef struct packed {
		logic [SITE_W-1:0]  rem;
		logic [SITE_W-1:0]  base;
		logic [COORD_W-1:0] y;
		logic [LEN_W-1:0]   ly;
		logic [LEN_W-1:0]   lx;
		logic [DIR_W-1:0]   dir;
		logic [SITE_W-1:0]  other;
		logic               err;
	} query_t;

	localparam int LAST = FRONT_STAGES - 1;

	logic [FRONT_STAGES-1:0] vld_s;
	query_t                  div_s [FRONT_STAGES];
	query_t                  entry;
	logic                    advance;

	// the whole divider moves as one; hold only when the tail item cannot enter the queue
	assign advance  = !(vld_s[LAST] && q_full);
	assign in_ready = advance;

	always_comb begin
		entry       = '0;
		entry.rem   = site;
		entry.base  = site;
		entry.ly    = step_length;
		entry.lx    = step_length;
		entry.dir   = dir;
		entry.other = other_site;
		entry.err   = ({1'b0, site} >= cfg.vol) ||
		              ({1'b0, step_length} >= cfg.ey) ||
		              ({1'b0, step_length} >= cfg.ex);
	end

	for (genvar i = 0; i < FRONT_STAGES; i++) begin : g_stage
		query_t             cur;
		query_t             nxt;
		logic [SITE_W-1:0]  rem_nxt;
		logic [SITE_W-1:0]  base_nxt;
		logic [COORD_W-1:0] y_nxt;
		logic [LEN_W-1:0]   ly_nxt;
		logic [LEN_W-1:0]   lx_nxt;

		if (i == 0) begin : g_first
			assign cur = entry;
		end else begin : g_next
			assign cur = div_s[i-1];
		end

		if (i < DIV1_STAGES) begin : g_mod_vol
			localparam int K = DIV1_STAGES - 1 - i;
			logic [SITE_W-1:0] part;
			logic              take;
			assign part     = cur.rem >> K;
			assign take     = {1'b0, part} >= cfg.vol;
			assign rem_nxt  = take ? cur.rem - SITE_W'(cfg.vol << K) : cur.rem;
			assign base_nxt = rem_nxt;
			assign y_nxt    = cur.y;
		end else begin : g_div_ex
			localparam int K = FRONT_STAGES - 1 - i;
			logic [SITE_W-1:0] part;
			logic              take;
			assign part     = cur.rem >> K;
			assign take     = part >= SITE_W'(cfg.ex);
			assign rem_nxt  = take ? cur.rem - (SITE_W'(cfg.ex) << K) : cur.rem;
			assign base_nxt = cur.base;
			always_comb begin
				y_nxt    = cur.y;
				y_nxt[K] = take;
			end
		end

		// step length reduced modulo each extent in the first stages
		if (i < LEN_W) begin : g_len_mod
			localparam int K = LEN_W - 1 - i;
			logic [LEN_W-1:0] ly_part;
			logic [LEN_W-1:0] lx_part;
			assign ly_part = cur.ly >> K;
			assign lx_part = cur.lx >> K;
			assign ly_nxt  = ({1'b0, ly_part} >= cfg.ey) ? cur.ly - LEN_W'(cfg.ey << K) : cur.ly;
			assign lx_nxt  = ({1'b0, lx_part} >= cfg.ex) ? cur.lx - LEN_W'(cfg.ex << K) : cur.lx;
		end else begin : g_len_hold
			assign ly_nxt = cur.ly;
			assign lx_nxt = cur.lx;
		end

		always_comb begin
			nxt      = cur;
			nxt.rem  = rem_nxt;
			nxt.base = base_nxt;
			nxt.y    = y_nxt;
			nxt.ly   = ly_nxt;
			nxt.lx   = lx_nxt;
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				div_s[i] <= nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (advance) begin
			vld_s <= {vld_s[FRONT_STAGES-2:0], in_valid};
		end
	end

	assign q_push       = vld_s[LAST] && !q_full;
	assign q_item.base  = div_s[LAST].base;
	assign q_item.y     = div_s[LAST].y;
	assign q_item.x     = div_s[LAST].rem[COORD_W-1:0];
	assign q_item.ly    = div_s[LAST].ly;
	assign q_item.lx    = div_s[LAST].lx;
	assign q_item.dir   = div_s[LAST].dir;
	assign q_item.other = div_s[LAST].other;
	assign q_item.err   = div_s[LAST].err;

endmodule

// ===== src/tln_queue.sv =====
// Small register FIFO that decouples the front from the back of the unit.
// Depends on nothing; width and depth come from parameters.
module tln_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/tln_back.sv =====
// Back of the neighbor index unit: moves the coordinates, finds the neighbor
// direction and bond index, and holds the result register. Depends on tln_pkg.
module tln_back
	import tln_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  lattice_cfg_t        cfg,
	input  logic                q_empty,
	input  q_item_t             q_item,
	output logic                q_pop,
	output logic                m_valid,
	input  logic                m_ready,
	output logic [COORD_W-1:0]  coord_y,
	output logic [COORD_W-1:0]  coord_x,
	output logic [SITE_W-1:0]   target_site,
	output logic [BOND_W-1:0]   bond_index,
	output logic                parity,
	output logic [DIR_W-1:0]    dir_to_other,
	output logic                range_error
);

	logic advance;

	// stage 1 registers
	logic               vld_s1;
	logic [COORD_W-1:0] y_s1;
	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] tx_s1;
	logic [SITE_W-1:0]  prod_s1;
	logic [SITE_W-1:0]  nbp_s1;
	logic [BOND_W-1:0]  mult_s1;
	logic               bond_en_s1;
	logic [DIR_W-1:0]   found_s1;
	logic               err_s1;

	// result registers
	logic               m_valid_q;
	logic [COORD_W-1:0] coord_y_q;
	logic [COORD_W-1:0] coord_x_q;
	logic [SITE_W-1:0]  target_q;
	logic [BOND_W-1:0]  bond_q;
	logic               parity_q;
	logic [DIR_W-1:0]   found_q;
	logic               err_q;

	// stage 1 logic
	logic [SITE_W-1:0]  up_y, dn_y, up_x, dn_x;
	logic [SITE_W-1:0]  nb [NUM_DIRS];
	logic [DIR_W-1:0]   found;
	logic [EXT_W-1:0]   y_sum, y_dif, x_sum, x_dif;
	logic [COORD_W-1:0] y_fwd, y_bwd, x_fwd, x_bwd, ty, tx;
	logic [VOL_W-1:0]   prod;
	logic [SITE_W-1:0]  nbp;
	logic [BOND_W-1:0]  mult;
	logic               bond_en;

	assign advance = !(m_valid_q && !m_ready);
	assign q_pop   = !q_empty && advance;

	// nearest-neighbor offsets, taken modulo 2^SITE_W; wrap across the lattice edge
	always_comb begin
		up_y = (q_item.y == COORD_W'(cfg.ey - EXT_W'(1))) ?
		       SITE_W'(cfg.ex) - SITE_W'(cfg.vol) : SITE_W'(cfg.ex);
		dn_y = (q_item.y == '0) ?
		       SITE_W'(cfg.vol) - SITE_W'(cfg.ex) : '0 - SITE_W'(cfg.ex);
		up_x = (q_item.x == COORD_W'(cfg.ex - EXT_W'(1))) ?
		       SITE_W'(1) - SITE_W'(cfg.ex) : SITE_W'(1);
		dn_x = (q_item.x == '0) ? SITE_W'(cfg.ex) - SITE_W'(1) : '1;

		nb[DIR_PY]   = q_item.base + up_y;
		nb[DIR_PX]   = q_item.base + up_x;
		nb[DIR_MYPX] = q_item.base + dn_y + up_x;
		nb[DIR_PYMX] = q_item.base + up_y + dn_x;
		nb[DIR_MX]   = q_item.base + dn_x;
		nb[DIR_MY]   = q_item.base + dn_y;

		// lowest matching direction wins
		found = DIR_NONE;
		for (int d = NUM_DIRS - 1; d >= 0; d--) begin
			if (nb[d] == q_item.other) begin
				found = DIR_W'(d);
			end
		end
	end

	// long move: step lengths are already reduced below each extent
	always_comb begin
		y_sum = {1'b0, q_item.y} + {1'b0, q_item.ly};
		y_dif = {1'b0, q_item.y} + cfg.ey - {1'b0, q_item.ly};
		x_sum = {1'b0, q_item.x} + {1'b0, q_item.lx};
		x_dif = {1'b0, q_item.x} + cfg.ex - {1'b0, q_item.lx};
		y_fwd = (y_sum >= cfg.ey) ? COORD_W'(y_sum - cfg.ey) : COORD_W'(y_sum);
		y_bwd = (q_item.y >= q_item.ly) ? q_item.y - q_item.ly : COORD_W'(y_dif);
		x_fwd = (x_sum >= cfg.ex) ? COORD_W'(x_sum - cfg.ex) : COORD_W'(x_sum);
		x_bwd = (q_item.x >= q_item.lx) ? q_item.x - q_item.lx : COORD_W'(x_dif);

		ty      = q_item.y;
		tx      = q_item.x;
		nbp     = q_item.base;
		mult    = '0;
		bond_en = 1'b1;
		case (q_item.dir)
			DIR_PY: begin
				ty = y_fwd;
			end
			DIR_PX: begin
				tx   = x_fwd;
				mult = BOND_W'(cfg.vol);
			end
			DIR_MYPX: begin
				ty   = y_bwd;
				tx   = x_fwd;
				mult = BOND_W'(cfg.vol) << 1;
			end
			DIR_PYMX: begin
				ty   = y_fwd;
				tx   = x_bwd;
				nbp  = nb[DIR_PYMX];
				mult = BOND_W'(cfg.vol) << 1;
			end
			DIR_MX: begin
				tx   = x_bwd;
				nbp  = nb[DIR_MX];
				mult = BOND_W'(cfg.vol);
			end
			DIR_MY: begin
				ty  = y_bwd;
				nbp = nb[DIR_MY];
			end
			default: begin
				bond_en = 1'b0;
			end
		endcase
		prod = VOL_W'(ty) * VOL_W'(cfg.ex);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			y_s1       <= q_item.y;
			x_s1       <= q_item.x;
			tx_s1      <= tx;
			prod_s1    <= SITE_W'(prod);
			nbp_s1     <= nbp;
			mult_s1    <= mult;
			bond_en_s1 <= bond_en;
			found_s1   <= found;
			err_s1     <= q_item.err;

			coord_y_q <= y_s1;
			coord_x_q <= x_s1;
			target_q  <= prod_s1 + SITE_W'(tx_s1);
			bond_q    <= bond_en_s1 ? BOND_W'(nbp_s1) + mult_s1 : '0;
			parity_q  <= y_s1[0] ^ x_s1[0];
			found_q   <= found_s1;
			err_q     <= err_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (advance) begin
			vld_s1    <= q_pop;
			m_valid_q <= vld_s1;
		end
	end

	assign m_valid      = m_valid_q;
	assign coord_y      = coord_y_q;
	assign coord_x      = coord_x_q;
	assign target_site  = target_q;
	assign bond_index   = bond_q;
	assign parity       = parity_q;
	assign dir_to_other = found_q;
	assign range_error  = err_q;

endmodule

// ===== src/triangular_lattice_neighbor_index_unit.sv =====
// Top level of the triangular lattice neighbor index unit: extent registers,
// front divider, decoupling queue and back datapath. Depends on tln_pkg.
//
// Usage:
//   Queries arrive on the s_ stream channel, one transaction per item; results
//   leave on the m_ stream channel, exactly one transaction per query, in order.
//   Extents are written over the cfg_ channel (index 0 extent_y, 1 extent_x);
//   write them only while no query is in flight. A zero extent acts as 1, one
//   above 1024 acts as 1024.
// Path and throughput:
//   An accepted query passes through the 30-stage divider that reduces the
//   site modulo the volume and then splits it by extent_x (one quotient bit
//   per stage, the first stage loads at the accepting edge), then through the
//   queue, the move stage and the result register.
//   One query per cycle is sustained while the receiver keeps m_tready high.
// Reset:
//   arst_n clears all valid flags and the queue and loads both extents with 16.
// Stall:
//   When m_tready is low under a valid result, it holds and the back stops; the
//   front keeps accepting until the queue and its last stage are full, then drops s_tready.
module triangular_lattice_neighbor_index_unit
	import tln_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// site[19:0], direction[22:20], step_length[32:23], other_site[52:33], zero pad
	input  logic [S_TDATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// coord_y[9:0], coord_x[19:10], target_site[39:20], bond_index[61:40],
	// parity[62], dir_to_other[65:63], zero pad
	output logic [M_TDATA_W-1:0]  m_tdata,
	// range_error
	output logic                  m_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [EXT_W-1:0]      cfg_data
);

	lattice_cfg_t       cfg;
	logic [EXT_W-1:0]   ey_q;
	logic [EXT_W-1:0]   ex_q;
	logic [VOL_W-1:0]   vol_q;
	logic [EXT_W-1:0]   ext_wr;
	logic [2*EXT_W-1:0] vol_wr_y;
	logic [2*EXT_W-1:0] vol_wr_x;

	logic               q_push;
	logic               q_pop;
	logic               q_full;
	logic               q_empty;
	q_item_t            q_wdata;
	q_item_t            q_rdata;

	logic [COORD_W-1:0] coord_y;
	logic [COORD_W-1:0] coord_x;
	logic [SITE_W-1:0]  target_site;
	logic [BOND_W-1:0]  bond_index;
	logic               parity;
	logic [DIR_W-1:0]   dir_to_other;

	// Extent registers hold the clamped values; the volume follows every write
	assign cfg_ready = 1'b1;
	assign ext_wr    = clamp_extent(cfg_data);
	assign vol_wr_y  = {{EXT_W{1'b0}}, ext_wr} * {{EXT_W{1'b0}}, ex_q};
	assign vol_wr_x  = {{EXT_W{1'b0}}, ey_q} * {{EXT_W{1'b0}}, ext_wr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ey_q  <= EXT_RESET;
			ex_q  <= EXT_RESET;
			vol_q <= VOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EXTENT_Y: begin
					ey_q  <= ext_wr;
					vol_q <= VOL_W'(vol_wr_y);
				end
				REG_EXTENT_X: begin
					ex_q  <= ext_wr;
					vol_q <= VOL_W'(vol_wr_x);
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.ey  = ey_q;
	assign cfg.ex  = ex_q;
	assign cfg.vol = vol_q;

	// Front: accept and split the site into coordinates
	tln_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.site        (s_tdata[19:0]),
		.dir         (s_tdata[22:20]),
		.step_length (s_tdata[32:23]),
		.other_site  (s_tdata[52:33]),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_wdata)
	);

	// Queue: lets the front keep accepting while the receiver stalls
	tln_queue #(
		.WIDTH ($bits(q_item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back: move, neighbor search, bond index, result register
	tln_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_empty      (q_empty),
		.q_item       (q_rdata),
		.q_pop        (q_pop),
		.m_valid      (m_tvalid),
		.m_ready      (m_tready),
		.coord_y      (coord_y),
		.coord_x      (coord_x),
		.target_site  (target_site),
		.bond_index   (bond_index),
		.parity       (parity),
		.dir_to_other (dir_to_other),
		.range_error  (m_tuser)
	);

	// Pack the result fields from the lowest bit up, pad to whole bytes
	assign m_tdata = {6'b0, dir_to_other, parity, bond_index, target_site, coord_x, coord_y};

endmodule

// ===== src/tln_checker.sv =====
// Port-level checks of the neighbor index unit, bound to its top level.
// Depends on tln_pkg and on the top-level port names.
module tln_checker
	import tln_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tuser
);

	// a stalled result stays offered and unchanged
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed or dropped while stalled");

	// no result is offered in the cycle after reset was seen applied
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result offered during reset");

	// parity follows the coordinates and the direction code stays in range
	a_result_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[62] == (m_tdata[0] ^ m_tdata[10])) &&
		             (m_tdata[65:63] <= DIR_NONE))
		else $error("inconsistent parity or direction in result");

endmodule

bind triangular_lattice_neighbor_index_unit tln_checker u_tln_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
